// ===== rtl/csbm_pkg.sv =====
`default_nettype none

package csbm_pkg;

   localparam int MAX_LEN     = 64;
   localparam int ALPHA       = 52;
   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = 6;
   localparam int LETTER_W    = 6;
   localparam int COUNT_W     = 7;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NON_LETTER = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG   = 2'd2;

   typedef struct packed {
      logic [7:0] cipher_char;
      logic [7:0] plain_char;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [5:0] best_shift;
      logic [6:0] best_score;
      logic [1:0] status;
      logic       last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DRAIN,
      ST_SEARCH,
      ST_SEARCH_LAST,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic accept;
      logic srch_issue;
      logic emit_issue;
      logic emit_load;
      logic emit_next;
      logic err_load;
      logic clear_run;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic srch_at_end;
      logic emit_last;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/caesar_shift_best_match.sv =====
`default_nettype none
// Pairs load at one item per cycle while the block waits in its load state; an item that
// is not marked last gives no result. After the last pair come a drain state, a search
// that reads the count memory for every shift and a closing search state, then for each
// letter a letter store read and a result load, which waits while the result is held.
// An error run gives its single result from the error state after the drain state.
// Reset is synchronous; it empties the counts, the pair count and the error; the store is not cleared.

module caesar_shift_best_match (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  csbm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output csbm_pkg::rsp_type  rsp_data
);
   import csbm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   csbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_pair),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csbm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/csbm_ctrl.sv =====
`default_nettype none

module csbm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   input  wire                 req_last,
   output logic                req_ready,
   input  csbm_pkg::stat_type  stat,
   output csbm_pkg::cmd_type   cmd
);
   import csbm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = stat.err ? ST_ERROR : ST_SEARCH;
         end
         ST_SEARCH: begin
            if (stat.srch_at_end) begin
               state_in = ST_SEARCH_LAST;
            end
         end
         ST_SEARCH_LAST: begin
            state_in = ST_EMIT_READ;
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (stat.rsp_free) begin
               state_in = stat.emit_last ? ST_LOAD : ST_EMIT_READ;
            end
         end
         ST_ERROR: begin
            if (stat.rsp_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SEARCH: begin
            cmd.srch_issue = 1'b1;
         end
         ST_EMIT_READ: begin
            cmd.emit_issue = 1'b1;
         end
         ST_EMIT_LOAD: begin
            if (stat.rsp_free) begin
               cmd.emit_load = 1'b1;
               cmd.emit_next = !stat.emit_last;
               cmd.clear_run = stat.emit_last;
            end
         end
         ST_ERROR: begin
            if (stat.rsp_free) begin
               cmd.err_load  = 1'b1;
               cmd.clear_run = 1'b1;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/csbm_dp.sv =====
`default_nettype none

module csbm_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  csbm_pkg::req_type   req_data,
   input  csbm_pkg::cmd_type   cmd,
   output csbm_pkg::stat_type  stat,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output csbm_pkg::rsp_type   rsp_data
);
   import csbm_pkg::*;

   function automatic logic is_letter(input logic [7:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
             ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
   endfunction

   function automatic logic [LETTER_W-1:0] letter_idx(input logic [7:0] b);
      logic [7:0] v;
      if (b <= CHAR_UPPER_Z) begin
         v = b - CHAR_UPPER_A;
      end else begin
         v = b - CHAR_LOWER_A + 8'd26;
      end
      return v[LETTER_W-1:0];
   endfunction

   // Letter store and count memory.
   logic [LETTER_W-1:0] store_mem [STORE_DEPTH];
   logic [COUNT_W-1:0]  cnt_mem   [ALPHA];

   logic [COUNT_W-1:0]  pair_count_ff, pair_count_in;
   logic [1:0]          error_ff, error_in;
   logic [ALPHA-1:0]    cnt_vld_ff, cnt_vld_in;
   logic                inc_vld_ff, wr_vld_ff;
   logic [LETTER_W-1:0] inc_addr_ff, wr_addr_ff;
   logic [COUNT_W-1:0]  wr_data_ff, cnt_rd_ff;
   logic [LETTER_W-1:0] srch_cnt_ff, srch_cnt_in, srch_idx_ff;
   logic                srch_vld_ff;
   logic [LETTER_W-1:0] best_k_ff, best_k_in;
   logic [COUNT_W-1:0]  best_s_ff, best_s_in;
   logic [STORE_AW-1:0] emit_idx_ff, emit_idx_in;
   logic [LETTER_W-1:0] store_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                c_ok, p_ok, full, pair_ok;
   logic [LETTER_W-1:0] ci, pi, k_addr, rd_addr, rot;
   logic [COUNT_W-1:0]  shift_sum, k_val, inc_old, inc_sum, srch_val, rot_sum;
   logic [7:0]          rot_char;

   always_comb begin
      c_ok      = is_letter(req_data.cipher_char);
      p_ok      = is_letter(req_data.plain_char);
      ci        = letter_idx(req_data.cipher_char);
      pi        = letter_idx(req_data.plain_char);
      full      = pair_count_ff >= COUNT_W'(MAX_LEN);
      pair_ok   = c_ok && p_ok && !full;
      // Shift that takes the cipher letter onto the reference letter, 1..52.
      shift_sum = {1'b0, pi} + COUNT_W'(ALPHA) - {1'b0, ci};
      k_val     = (shift_sum > COUNT_W'(ALPHA)) ? shift_sum - COUNT_W'(ALPHA) : shift_sum;
      k_addr    = LETTER_W'(k_val - 7'd1);
      rd_addr   = cmd.srch_issue ? srch_cnt_ff : k_addr;
   end

   always_comb begin
      error_in = error_ff;
      if (cmd.clear_run) begin
         error_in = STAT_OK;
      end else if (cmd.accept && (error_ff == STAT_OK)) begin
         if (!(c_ok && p_ok)) begin
            error_in = STAT_NON_LETTER;
         end else if (full) begin
            error_in = STAT_TOO_LONG;
         end
      end
      pair_count_in = pair_count_ff;
      if (cmd.clear_run) begin
         pair_count_in = '0;
      end else if (cmd.accept && pair_ok) begin
         pair_count_in = pair_count_ff + 7'd1;
      end
   end

   // The write of the previous item has not reached the read of this one yet.
   always_comb begin
      if (wr_vld_ff && (wr_addr_ff == inc_addr_ff)) begin
         inc_old = wr_data_ff;
      end else if (cnt_vld_ff[inc_addr_ff]) begin
         inc_old = cnt_rd_ff;
      end else begin
         inc_old = '0;
      end
      inc_sum = inc_old + 7'd1;
      cnt_vld_in = cnt_vld_ff;
      if (cmd.clear_run) begin
         cnt_vld_in = '0;
      end else if (inc_vld_ff) begin
         cnt_vld_in[inc_addr_ff] = 1'b1;
      end
   end

   always_comb begin
      srch_cnt_in = srch_cnt_ff;
      if (cmd.srch_issue) begin
         srch_cnt_in = (srch_cnt_ff == LETTER_W'(ALPHA - 1)) ? '0 : srch_cnt_ff + 6'd1;
      end
      srch_val  = cnt_vld_ff[srch_idx_ff] ? cnt_rd_ff : '0;
      best_k_in = best_k_ff;
      best_s_in = best_s_ff;
      if (srch_vld_ff && ((srch_idx_ff == '0) || (srch_val > best_s_ff))) begin
         best_k_in = srch_idx_ff + 6'd1;
         best_s_in = srch_val;
      end
      emit_idx_in = emit_idx_ff;
      if (cmd.clear_run) begin
         emit_idx_in = '0;
      end else if (cmd.emit_next) begin
         emit_idx_in = emit_idx_ff + 6'd1;
      end
   end

   always_comb begin
      rot_sum = {1'b0, store_rd_ff} + {1'b0, best_k_ff};
      rot     = (rot_sum >= COUNT_W'(ALPHA)) ? LETTER_W'(rot_sum - COUNT_W'(ALPHA))
                                             : LETTER_W'(rot_sum);
      if (rot < 6'd26) begin
         rot_char = CHAR_UPPER_A + {2'b00, rot};
      end else begin
         rot_char = CHAR_LOWER_A + {2'b00, rot} - 8'd26;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.emit_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_char    = rot_char;
         rsp_in.best_shift  = best_k_ff;
         rsp_in.best_score  = best_s_ff;
         rsp_in.status      = STAT_OK;
         rsp_in.last_out    = stat.emit_last;
      end else if (cmd.err_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_char    = '0;
         rsp_in.best_shift  = '0;
         rsp_in.best_score  = '0;
         rsp_in.status      = error_ff;
         rsp_in.last_out    = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         error_ff      <= STAT_OK;
         cnt_vld_ff    <= '0;
         inc_vld_ff    <= 1'b0;
         wr_vld_ff     <= 1'b0;
         srch_cnt_ff   <= '0;
         srch_vld_ff   <= 1'b0;
         emit_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_count_ff <= pair_count_in;
         error_ff      <= error_in;
         cnt_vld_ff    <= cnt_vld_in;
         inc_vld_ff    <= cmd.accept && pair_ok;
         wr_vld_ff     <= inc_vld_ff && !cmd.clear_run;
         srch_cnt_ff   <= srch_cnt_in;
         srch_vld_ff   <= cmd.srch_issue;
         emit_idx_ff   <= emit_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_addr_ff <= k_addr;
      wr_addr_ff  <= inc_addr_ff;
      wr_data_ff  <= inc_sum;
      srch_idx_ff <= srch_cnt_ff;
      best_k_ff   <= best_k_in;
      best_s_ff   <= best_s_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && pair_ok) begin
         store_mem[pair_count_ff[STORE_AW-1:0]] <= ci;
      end
      if (cmd.emit_issue) begin
         store_rd_ff <= store_mem[emit_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (inc_vld_ff) begin
         cnt_mem[inc_addr_ff] <= inc_sum;
      end
      if ((cmd.accept && pair_ok) || cmd.srch_issue) begin
         cnt_rd_ff <= cnt_mem[rd_addr];
      end
   end

   always_comb begin
      stat.err         = error_ff != STAT_OK;
      stat.srch_at_end = srch_cnt_ff == LETTER_W'(ALPHA - 1);
      stat.emit_last   = {1'b0, emit_idx_ff} == (pair_count_ff - 7'd1);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= COUNT_W'(MAX_LEN))
      else $error("pair count beyond maximum length");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      srch_vld_ff |-> !inc_vld_ff)
      else $error("search read overlaps count update");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.err_load) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   a_err_load: assert property (@(posedge clock) disable iff (reset)
      cmd.err_load |-> (error_ff != STAT_OK))
      else $error("error result without recorded error");

   a_ok_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |=> (rsp_ff.best_shift != 6'd0) && (rsp_ff.best_shift <= 6'd52))
      else $error("chosen shift out of range");

endmodule

`default_nettype wire

// ===== tb/csbm_checker.sv =====
module csbm_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  csbm_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  csbm_pkg::rsp_type  rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 letters_seen,
   output int                 error_results_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import csbm_pkg::*;

   logic [LETTER_W-1:0] text_idx [STORE_DEPTH];
   logic [COUNT_W-1:0]  shift_hits [ALPHA];
   int                  pairs_held;
   logic [1:0]          run_error;
   rsp_type             rotated_due [$];
   int                  fails;
   int                  letters;
   int                  error_results;

   function automatic int letter_code(input logic [7:0] b);
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return int'(b - CHAR_UPPER_A);
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return int'(b - CHAR_LOWER_A) + 26;
      return -1;
   endfunction

   function automatic logic [7:0] letter_ascii(input int idx);
      if (idx < 26) return CHAR_UPPER_A + 8'(idx);
      return CHAR_LOWER_A + 8'(idx - 26);
   endfunction

   task automatic clear_text();
      for (int k = 0; k < ALPHA; k++) shift_hits[k] = '0;
      pairs_held = 0;
      run_error  = STAT_OK;
   endtask

   // Counts the pair's shift and, on the last pair, queues the rotated text or the error.
   task automatic tally_pair(input req_type item);
      int      ci;
      int      pi;
      int      k;
      int      best_k;
      int      best_s;
      rsp_type want;
      ci = letter_code(item.cipher_char);
      pi = letter_code(item.plain_char);
      if (ci < 0 || pi < 0) begin
         if (run_error == STAT_OK) run_error = STAT_NON_LETTER;
      end else if (pairs_held >= MAX_LEN) begin
         if (run_error == STAT_OK) run_error = STAT_TOO_LONG;
      end else begin
         k = (pi + ALPHA - ci) % ALPHA;
         if (k == 0) k = ALPHA;
         shift_hits[k-1] = shift_hits[k-1] + 1'b1;
         text_idx[pairs_held] = LETTER_W'(ci);
         pairs_held++;
      end
      if (!item.last_pair) return;
      if (run_error != STAT_OK) begin
         want.out_char   = '0;
         want.best_shift = '0;
         want.best_score = '0;
         want.status     = run_error;
         want.last_out   = 1'b1;
         rotated_due.push_back(want);
      end else begin
         best_k = 1;
         best_s = shift_hits[0];
         for (int s = 2; s <= ALPHA; s++) begin
            if (shift_hits[s-1] > best_s) begin
               best_s = shift_hits[s-1];
               best_k = s;
            end
         end
         for (int i = 0; i < pairs_held; i++) begin
            want.out_char   = letter_ascii((int'(text_idx[i]) + best_k) % ALPHA);
            want.best_shift = 6'(best_k);
            want.best_score = 7'(best_s);
            want.status     = STAT_OK;
            want.last_out   = (i == pairs_held - 1);
            rotated_due.push_back(want);
         end
      end
      clear_text();
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_text();
         rotated_due.delete();
         fails         = 0;
         letters       = 0;
         error_results = 0;
      end else begin
         if (req_valid && req_ready) tally_pair(req_data);
         if (rsp_valid && rsp_ready) begin
            if (rotated_due.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result: char %h shift %0d score %0d status %0d last %0b",
                           rsp_data.out_char, rsp_data.best_shift, rsp_data.best_score,
                           rsp_data.status, rsp_data.last_out);
            end else begin
               want = rotated_due.pop_front();
               if (want.status == STAT_OK) letters++;
               else error_results++;
               if (rsp_data.out_char !== want.out_char ||
                   rsp_data.best_shift !== want.best_shift ||
                   rsp_data.best_score !== want.best_score ||
                   rsp_data.status !== want.status ||
                   rsp_data.last_out !== want.last_out) begin
                  fails++;
                  if (fails <= 10)
                     $display({"mismatch: expected char %h shift %0d score %0d status %0d",
                               " last %0b, got char %h shift %0d score %0d status %0d last %0b"},
                              want.out_char, want.best_shift, want.best_score, want.status,
                              want.last_out, rsp_data.out_char, rsp_data.best_shift,
                              rsp_data.best_score, rsp_data.status, rsp_data.last_out);
               end
            end
         end
      end
      fail_count         <= fails;
      pending_count      <= rotated_due.size();
      letters_seen       <= letters;
      error_results_seen <= error_results;
   end

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import csbm_pkg::*;

   localparam int IDLE_PCT    = 36;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    req_ready;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int letters_seen;
   int error_results_seen;
   int pairs_sent  = 0;
   int texts_sent  = 0;
   int quiet_cycles = 0;
   int hold_asks   = 0;
   int holds_done  = 0;
   logic calm      = 1'b0;

   caesar_shift_best_match uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   csbm_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_data           (rsp_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .letters_seen       (letters_seen),
      .error_results_seen (error_results_seen)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("caesar_shift_best_match test failed");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_asks) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
         end
      end
   end

   function automatic logic [7:0] ascii_of(input int idx);
      if (idx < 26) return CHAR_UPPER_A + 8'(idx);
      return CHAR_LOWER_A + 8'(idx - 26);
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic offer_pair(input logic [7:0] c, input logic [7:0] p, input logic last);
      req_type item;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.cipher_char = c;
      item.plain_char  = p;
      item.last_pair   = last;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      pairs_sent++;
      if (last) texts_sent++;
   endtask

   // A text in which a chosen share of pairs agrees on one shift, with optional stray bytes.
   task automatic send_text(input int len, input int shift, input int noise_pct,
                            input int match_pct);
      int         ci;
      int         pi;
      logic [7:0] c;
      logic [7:0] p;
      for (int i = 0; i < len; i++) begin
         ci = $urandom_range(0, ALPHA - 1);
         if ($urandom_range(99) < match_pct) pi = (ci + shift) % ALPHA;
         else pi = $urandom_range(0, ALPHA - 1);
         c = ascii_of(ci);
         p = ascii_of(pi);
         if ($urandom_range(99) < noise_pct) c = 8'($urandom_range(0, 255));
         if ($urandom_range(99) < noise_pct) p = 8'($urandom_range(0, 255));
         offer_pair(c, p, i == len - 1);
      end
   endtask

   task automatic random_texts(input int pair_goal);
      int goal;
      int len;
      goal = pairs_sent + pair_goal;
      while (pairs_sent < goal) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         send_text(len, $urandom_range(1, ALPHA),
                   ($urandom_range(99) < 15) ? 25 : 0, $urandom_range(30, 100));
      end
   endtask

   // The checker's count is registered, so look only after the next edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity shift on a single letter, then wait for it before going on.
      offer_pair(CHAR_UPPER_A, CHAR_UPPER_A, 1'b1);
      wait_drained();
      // Wrap at both ends of the alphabet.
      offer_pair(CHAR_LOWER_Z, CHAR_UPPER_A, 1'b0);
      offer_pair(CHAR_UPPER_Z, CHAR_LOWER_A, 1'b1);
      // Two shifts tie at one; the smaller one wins.
      offer_pair(CHAR_UPPER_A, CHAR_UPPER_A + 8'd2, 1'b0);
      offer_pair(CHAR_UPPER_A, CHAR_UPPER_A + 8'd1, 1'b1);
      // Non-letters in the cipher byte and in the reference byte.
      offer_pair(8'h00, CHAR_UPPER_A, 1'b0);
      offer_pair(CHAR_UPPER_A + 8'd1, CHAR_UPPER_A + 8'd1, 1'b1);
      offer_pair(CHAR_LOWER_A, 8'hFF, 1'b1);
      // Bytes just outside each letter range.
      offer_pair(CHAR_UPPER_A - 8'd1, CHAR_UPPER_A, 1'b0);
      offer_pair(CHAR_UPPER_A, CHAR_UPPER_Z + 8'd1, 1'b0);
      offer_pair(CHAR_LOWER_A - 8'd1, CHAR_LOWER_A, 1'b0);
      offer_pair(CHAR_LOWER_Z, CHAR_LOWER_Z + 8'd1, 1'b1);
      offer_pair(8'hAA, 8'h55, 1'b0);
      offer_pair(8'h55, 8'hAA, 1'b1);
      send_text(5, 26, 0, 100);

      random_texts(20);
      calm <= 1'b1;
      random_texts(20);
      calm <= 1'b0;
      // Hold the result side while more texts keep coming.
      hold_asks <= hold_asks + 1;
      random_texts(15);

      // A full-length text that matches everywhere gives the top score.
      send_text(MAX_LEN, $urandom_range(1, ALPHA), 0, 100);
      wait_drained();
      // One pair too many, then a non-letter: the overflow is reported.
      for (int i = 0; i < MAX_LEN; i++) begin
         offer_pair(ascii_of($urandom_range(0, ALPHA - 1)),
                    ascii_of($urandom_range(0, ALPHA - 1)), 1'b0);
      end
      offer_pair(ascii_of($urandom_range(0, ALPHA - 1)), ascii_of($urandom_range(0, ALPHA - 1)),
                 1'b0);
      offer_pair(8'($urandom_range(0, 8'h40)), CHAR_UPPER_A, 1'b1);
      random_texts(10);
      wait_drained();
      random_texts(5);

      wait_drained();
      repeat (60) @(posedge clock);

      $display("sent %0d pairs in %0d texts, checked %0d letters and %0d error results",
               pairs_sent, texts_sent, letters_seen, error_results_seen);
      $display("covered wraps, ties, identity shift, stray bytes, full length and overflow");
      if (fail_count == 0 && pending_count == 0) begin
         $display("caesar_shift_best_match test passed");
      end else begin
         $display("caesar_shift_best_match test failed");
      end
      $finish;
   end

endmodule
